### rtl/mca_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mca_pkg;
  localparam int MAX_SIZE_DEF  = 64;
  localparam int COST_BITS_DEF = 20;
  localparam int CFG_W         = 7;
  localparam int IDX_OUT_W     = 6;
endpackage
`default_nettype wire

### rtl/mca_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface mca_in_if #(
  parameter int COST_BITS = mca_pkg::COST_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic [COST_BITS-1:0] cost;
  logic                 last_entry;

  modport source (output valid, cost, last_entry, input ready);
  modport sink   (input valid, cost, last_entry, output ready);
endinterface
`default_nettype wire

### rtl/mca_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface mca_out_if;
  logic                           valid;
  logic                           ready;
  logic [mca_pkg::IDX_OUT_W-1:0]  column_index;
  logic [mca_pkg::IDX_OUT_W-1:0]  assigned_row;
  logic                           last_result;

  modport source (output valid, column_index, assigned_row, last_result, input ready);
  modport sink   (input valid, column_index, assigned_row, last_result, output ready);
endinterface
`default_nettype wire

### rtl/mca_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module mca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### rtl/mca_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared subtract-and-compare unit: res = a - b - c, lt = res < cmp.
module mca_alu #(
  parameter int W = 32
) (
  input  wire logic signed [W-1:0] a,
  input  wire logic signed [W-1:0] b,
  input  wire logic signed [W-1:0] c,
  input  wire logic signed [W-1:0] cmp,
  output logic signed [W-1:0]      res,
  output logic                     lt
);
  always_comb begin
    res = a - b - c;
    lt  = res < cmp;
  end
endmodule
`default_nettype wire

### rtl/min_cost_assignment_solver.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Dir  Payload                                   Handshake
// in_ch     in   cost, last_entry                          valid/ready
// out_ch    out  column_index, assigned_row, last_result   valid/ready
// cfg_*     in   cfg_data = matrix size n                  cfg_we, no wait
//
// Loading takes one cost per cycle; in_ch.ready is high only while loading.
// The solve runs on one shared subtract/compare unit and is bounded by the
// single read port of each memory. Results then leave one transaction at a
// time, each waiting on out_ch.ready before the next one is prepared.
// Reset (rst_n, synchronous, active low) clears control state and sets the
// size to 1; the memories are not cleared, and a load that ends early leaves
// stale costs in the cost entries that it did not write.
module min_cost_assignment_solver #(
  parameter int MAX_SIZE  = mca_pkg::MAX_SIZE_DEF,
  parameter int COST_BITS = mca_pkg::COST_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  mca_in_if.sink                         in_ch,
  mca_out_if.source                      out_ch,
  input  wire logic                      cfg_we,
  input  wire logic [mca_pkg::CFG_W-1:0] cfg_data
);
  localparam int IW    = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam int NW    = $clog2(MAX_SIZE + 1);
  localparam int DEPTH = MAX_SIZE * MAX_SIZE;
  localparam int AW    = $clog2(DEPTH);
  localparam int LW    = COST_BITS + IW + 3;   // label and slack width

  typedef enum logic [3:0] {
    S_LOAD, S_INIT, S_ROWMIN, S_COLMIN, S_ROOT, S_PREP, S_SROW,
    S_FIND, S_UPD, S_CHKY, S_WALK, S_OUT, S_OWAIT
  } state_t;

  state_t                st_r, st_nxt;
  logic [1:0]            ph_r, ph_nxt;
  logic [IW-1:0]         i_r, i_nxt, j_r, j_nxt, y_r, y_nxt, z_r, z_nxt, x_r, x_nxt;
  logic [AW-1:0]         a_r, a_nxt, zb_r, zb_nxt;
  logic [AW:0]           ld_r, ld_nxt;
  logic signed [LW-1:0]  m_r, m_nxt, al_r, al_nxt, uz_r, uz_nxt;
  logic                  yv_r, yv_nxt, alv_r, alv_nxt, init_r, init_nxt;
  logic [MAX_SIZE-1:0]   rm_r, rm_nxt, cm_r, cm_nxt, rt_r, rt_nxt, ct_r, ct_nxt;
  logic [NW-1:0]         mc_r, mc_nxt;
  logic [mca_pkg::CFG_W-1:0] n_r;
  logic                  ov_r, ov_nxt, olast_r, olast_nxt;
  logic [IW-1:0]         oc_r, oc_nxt, orow_r, orow_nxt;

  // active size and derived bounds
  logic [NW-1:0]         na;
  logic [2*NW-1:0]       nn;
  logic [IW-1:0]         nm1;
  always_comb begin
    if (n_r == '0) begin
      na = NW'(1);
    end else if (32'(n_r) > MAX_SIZE) begin
      na = NW'(MAX_SIZE);
    end else begin
      na = NW'(n_r);
    end
    nn  = (2*NW)'(na) * (2*NW)'(na);
    nm1 = IW'(na - NW'(1));
  end

  // memory ports
  logic                 c_we;   logic [AW-1:0] c_wa, c_ra; logic [COST_BITS-1:0] c_wd, c_rd;
  logic                 u_we;   logic [IW-1:0] u_wa, u_ra; logic [LW-1:0] u_wd, u_rd;
  logic                 v_we;   logic [IW-1:0] v_wa, v_ra; logic [LW-1:0] v_wd, v_rd;
  logic                 s_we;   logic [IW-1:0] s_wa, s_ra; logic [LW-1:0] s_wd, s_rd;
  logic                 q_we;   logic [IW-1:0] q_wa, q_ra, q_wd, q_rd;
  logic                 t_we;   logic [IW-1:0] t_wa, t_ra, t_wd, t_rd;
  logic                 rp_we;  logic [IW-1:0] rp_wa, rp_ra, rp_wd, rp_rd;
  logic                 cp_we;  logic [IW-1:0] cp_wa, cp_ra, cp_wd, cp_rd;

  mca_ram #(.WIDTH(COST_BITS), .DEPTH(DEPTH)) u_cost (
    .clk, .we(c_we), .waddr(c_wa), .wdata(c_wd), .raddr(c_ra), .rdata(c_rd));
  mca_ram #(.WIDTH(LW), .DEPTH(MAX_SIZE)) u_ulab (
    .clk, .we(u_we), .waddr(u_wa), .wdata(u_wd), .raddr(u_ra), .rdata(u_rd));
  mca_ram #(.WIDTH(LW), .DEPTH(MAX_SIZE)) u_vlab (
    .clk, .we(v_we), .waddr(v_wa), .wdata(v_wd), .raddr(v_ra), .rdata(v_rd));
  mca_ram #(.WIDTH(LW), .DEPTH(MAX_SIZE)) u_slack (
    .clk, .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(s_ra), .rdata(s_rd));
  mca_ram #(.WIDTH(IW), .DEPTH(MAX_SIZE)) u_ssrc (
    .clk, .we(q_we), .waddr(q_wa), .wdata(q_wd), .raddr(q_ra), .rdata(q_rd));
  mca_ram #(.WIDTH(IW), .DEPTH(MAX_SIZE)) u_tpar (
    .clk, .we(t_we), .waddr(t_wa), .wdata(t_wd), .raddr(t_ra), .rdata(t_rd));
  mca_ram #(.WIDTH(IW), .DEPTH(MAX_SIZE)) u_rpart (
    .clk, .we(rp_we), .waddr(rp_wa), .wdata(rp_wd), .raddr(rp_ra), .rdata(rp_rd));
  mca_ram #(.WIDTH(IW), .DEPTH(MAX_SIZE)) u_cpart (
    .clk, .we(cp_we), .waddr(cp_wa), .wdata(cp_wd), .raddr(cp_ra), .rdata(cp_rd));

  // shared arithmetic unit
  logic signed [LW-1:0] op_a, op_b, op_c, op_cmp, alu_res;
  logic                 alu_lt;
  mca_alu #(.W(LW)) u_alu (
    .a(op_a), .b(op_b), .c(op_c), .cmp(op_cmp), .res(alu_res), .lt(alu_lt));

  // first unmatched row
  logic [IW-1:0] root;
  always_comb begin
    root = '0;
    for (int k = MAX_SIZE - 1; k >= 0; k--) begin
      if (!rm_r[k]) begin
        root = IW'(k);
      end
    end
  end

  assign in_ch.ready         = (st_r == S_LOAD);
  assign out_ch.valid        = ov_r;
  assign out_ch.column_index = mca_pkg::IDX_OUT_W'(oc_r);
  assign out_ch.assigned_row = mca_pkg::IDX_OUT_W'(orow_r);
  assign out_ch.last_result  = olast_r;

  always_comb begin
    logic signed [LW-1:0] mcur;
    logic [IW-1:0]        xv;
    st_nxt = st_r;   ph_nxt = ph_r;   i_nxt = i_r;   j_nxt = j_r;
    y_nxt = y_r;     z_nxt = z_r;     x_nxt = x_r;   a_nxt = a_r;
    zb_nxt = zb_r;   ld_nxt = ld_r;   m_nxt = m_r;   al_nxt = al_r;
    uz_nxt = uz_r;   yv_nxt = yv_r;   alv_nxt = alv_r; init_nxt = init_r;
    rm_nxt = rm_r;   cm_nxt = cm_r;   rt_nxt = rt_r; ct_nxt = ct_r;
    mc_nxt = mc_r;   ov_nxt = ov_r;   olast_nxt = olast_r;
    oc_nxt = oc_r;   orow_nxt = orow_r;
    mcur = m_r;      xv = t_rd;
    c_we = 1'b0;  c_wa = ld_r[AW-1:0]; c_wd = in_ch.cost; c_ra = a_r;
    u_we = 1'b0;  u_wa = i_r; u_wd = '0; u_ra = i_r;
    v_we = 1'b0;  v_wa = j_r; v_wd = '0; v_ra = j_r;
    s_we = 1'b0;  s_wa = j_r; s_wd = alu_res; s_ra = j_r;
    q_we = 1'b0;  q_wa = j_r; q_wd = z_r; q_ra = y_r;
    t_we = 1'b0;  t_wa = y_r; t_wd = q_rd; t_ra = y_r;
    rp_we = 1'b0; rp_wa = x_r; rp_wd = y_r; rp_ra = t_rd;
    cp_we = 1'b0; cp_wa = y_r; cp_wd = t_rd; cp_ra = y_r;
    op_a = LW'(c_rd); op_b = '0; op_c = '0; op_cmp = m_r;

    case (st_r)
      S_LOAD: begin
        if (in_ch.valid) begin
          if ((2*NW+AW+1)'(ld_r) < (2*NW+AW+1)'(nn)) begin
            c_we   = 1'b1;
            ld_nxt = ld_r + 1'b1;
          end
          if (in_ch.last_entry) begin
            st_nxt = S_INIT;
          end
        end
      end
      S_INIT: begin
        rm_nxt = '0; cm_nxt = '0; mc_nxt = '0;
        i_nxt = '0;  j_nxt = '0;  a_nxt = '0; ph_nxt = '0;
        st_nxt = S_ROWMIN;
      end
      S_ROWMIN: begin
        if (ph_r == 2'd0) begin
          ph_nxt = 2'd1;
        end else begin
          mcur   = (j_r == '0 || alu_lt) ? alu_res : m_r;
          m_nxt  = mcur;
          a_nxt  = a_r + 1'b1;
          ph_nxt = 2'd0;
          if (j_r == nm1) begin
            u_we  = 1'b1; u_wd = mcur;
            j_nxt = '0;
            if (i_r == nm1) begin
              st_nxt = S_COLMIN; i_nxt = '0; a_nxt = '0;
            end else begin
              i_nxt = i_r + 1'b1;
            end
          end else begin
            j_nxt = j_r + 1'b1;
          end
        end
      end
      S_COLMIN: begin
        op_b = u_rd;
        if (ph_r == 2'd0) begin
          ph_nxt = 2'd1;
        end else begin
          mcur   = (i_r == '0 || alu_lt) ? alu_res : m_r;
          m_nxt  = mcur;
          ph_nxt = 2'd0;
          if (i_r == nm1) begin
            v_we  = 1'b1; v_wd = mcur;
            i_nxt = '0;
            if (j_r == nm1) begin
              st_nxt = S_ROOT;
            end else begin
              j_nxt = j_r + 1'b1;
              a_nxt = AW'(j_r) + 1'b1;
            end
          end else begin
            i_nxt = i_r + 1'b1;
            a_nxt = a_r + AW'(na);
          end
        end
      end
      S_ROOT: begin
        if (mc_r == na) begin
          st_nxt = S_OUT; j_nxt = '0; ph_nxt = '0;
        end else begin
          rt_nxt = '0; rt_nxt[root] = 1'b1;
          ct_nxt = '0;
          z_nxt = root; init_nxt = 1'b1;
          st_nxt = S_PREP; ph_nxt = '0;
        end
      end
      S_PREP: begin
        u_ra = z_r;
        if (ph_r == 2'd0) begin
          zb_nxt = AW'(AW'(z_r) * AW'(na));
          ph_nxt = 2'd1;
        end else begin
          uz_nxt = u_rd; j_nxt = '0; ph_nxt = '0;
          st_nxt = S_SROW;
        end
      end
      S_SROW: begin
        c_ra = zb_r + AW'(j_r);
        op_b = uz_r; op_c = v_rd; op_cmp = s_rd;
        if (ph_r == 2'd0) begin
          ph_nxt = 2'd1;
        end else begin
          ph_nxt = 2'd0;
          if (init_r || alu_lt) begin
            s_we = 1'b1; q_we = 1'b1;
          end
          if (j_r == nm1) begin
            st_nxt = S_FIND; j_nxt = '0; init_nxt = 1'b0;
            yv_nxt = 1'b0; alv_nxt = 1'b0;
          end else begin
            j_nxt = j_r + 1'b1;
          end
        end
      end
      S_FIND: begin
        op_a = s_rd; op_cmp = al_r;
        if (ph_r == 2'd0) begin
          ph_nxt = 2'd1;
        end else begin
          ph_nxt = 2'd0;
          if (!ct_r[j_r]) begin
            if (alu_res == '0) begin
              y_nxt = j_r; yv_nxt = 1'b1;
            end
            if (!alv_r || alu_lt) begin
              al_nxt = alu_res; alv_nxt = 1'b1;
            end
          end
          if (j_r == nm1) begin
            j_nxt  = '0;
            st_nxt = yv_nxt ? S_CHKY : S_UPD;
          end else begin
            j_nxt = j_r + 1'b1;
          end
        end
      end
      S_UPD: begin
        op_a = s_rd; op_b = al_r;
        u_ra = j_r; u_wa = j_r;
        if (ph_r == 2'd0) begin
          ph_nxt = 2'd1;
        end else begin
          ph_nxt = 2'd0;
          u_wd = u_rd + al_r;
          v_wd = v_rd - al_r;
          u_we = rt_r[j_r];
          v_we = ct_r[j_r];
          if (!ct_r[j_r]) begin
            s_we = 1'b1;
            if (alu_res == '0) begin
              y_nxt = j_r; yv_nxt = 1'b1;
            end
          end
          if (j_r == nm1) begin
            j_nxt = '0; st_nxt = S_CHKY;
          end else begin
            j_nxt = j_r + 1'b1;
          end
        end
      end
      S_CHKY: begin
        if (ph_r == 2'd0) begin
          ph_nxt = 2'd1;
        end else begin
          t_we = 1'b1;
          ph_nxt = '0;
          if (cm_r[y_r]) begin
            z_nxt = cp_rd;
            rt_nxt[cp_rd] = 1'b1;
            ct_nxt[y_r]   = 1'b1;
            st_nxt = S_PREP;
          end else begin
            st_nxt = S_WALK;
          end
        end
      end
      S_WALK: begin
        case (ph_r)
          2'd0: ph_nxt = 2'd1;
          2'd1: begin
            xv = t_rd;
            cp_we = 1'b1;
            cm_nxt[y_r] = 1'b1;
            x_nxt  = xv;
            ph_nxt = 2'd2;
          end
          default: begin
            rp_we = 1'b1;
            rm_nxt[x_r] = 1'b1;
            ph_nxt = 2'd0;
            if (rm_r[x_r]) begin
              y_nxt = rp_rd;
            end else begin
              mc_nxt = mc_r + 1'b1;
              st_nxt = S_ROOT;
            end
          end
        endcase
      end
      S_OUT: begin
        cp_ra = j_r;
        if (ph_r == 2'd0) begin
          ph_nxt = 2'd1;
        end else begin
          orow_nxt = cp_rd; oc_nxt = j_r;
          olast_nxt = (j_r == nm1);
          ov_nxt = 1'b1; ph_nxt = '0;
          st_nxt = S_OWAIT;
        end
      end
      S_OWAIT: begin
        if (out_ch.ready) begin
          ov_nxt = 1'b0;
          if (j_r == nm1) begin
            ld_nxt = '0; st_nxt = S_LOAD;
          end else begin
            j_nxt = j_r + 1'b1; st_nxt = S_OUT;
          end
        end
      end
      default: st_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_LOAD; ph_r <= '0; ld_r <= '0; mc_r <= '0;
      rm_r <= '0; cm_r <= '0; rt_r <= '0; ct_r <= '0;
      yv_r <= 1'b0; alv_r <= 1'b0; init_r <= 1'b0; ov_r <= 1'b0;
      n_r <= mca_pkg::CFG_W'(1);
    end else begin
      st_r <= st_nxt; ph_r <= ph_nxt; ld_r <= ld_nxt; mc_r <= mc_nxt;
      rm_r <= rm_nxt; cm_r <= cm_nxt; rt_r <= rt_nxt; ct_r <= ct_nxt;
      yv_r <= yv_nxt; alv_r <= alv_nxt; init_r <= init_nxt; ov_r <= ov_nxt;
      if (cfg_we) begin
        n_r <= cfg_data;
      end
    end
    i_r <= i_nxt; j_r <= j_nxt; y_r <= y_nxt; z_r <= z_nxt; x_r <= x_nxt;
    a_r <= a_nxt; zb_r <= zb_nxt; m_r <= m_nxt; al_r <= al_nxt; uz_r <= uz_nxt;
    olast_r <= olast_nxt; oc_r <= oc_nxt; orow_r <= orow_nxt;
  end

`ifndef ASSERT_OFF
  // never load and present a result at once
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid)) else $error("load overlaps result");
  // matched count stays within the active size while solving and emitting
  a_mc: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_LOAD && st_r != S_INIT) |-> (mc_r <= na))
    else $error("matched count overflow");
  // after the final result the block is back to loading
  a_ret: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && out_ch.last_result) |=> in_ch.ready)
    else $error("no return to loading");
`endif
endmodule
`default_nettype wire

### dv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import mca_pkg::*;

  typedef struct {
    logic [COST_BITS_DEF-1:0] cost;
    logic                     last_entry;
  } cost_txn_t;

  typedef struct {
    logic [IDX_OUT_W-1:0] column_index;
    logic [IDX_OUT_W-1:0] assigned_row;
    logic                 last_result;
  } match_txn_t;

  localparam int NO_IDX = -1;
  localparam int LONG_HOLD_CYCLES = 400;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_W-1:0] cfg_data;

  mca_in_if  in_ch ();
  mca_out_if out_ch ();

  min_cost_assignment_solver u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data)
  );

  // Pending cost transactions and the matches they are predicted to produce
  cost_txn_t  cost_queue[$];
  match_txn_t match_queue[$];

  // Shadow copy of the solver state
  logic [COST_BITS_DEF-1:0] cost_mem [MAX_SIZE_DEF*MAX_SIZE_DEF];
  int unsigned load_cnt;
  int unsigned size_reg;

  longint row_lbl [MAX_SIZE_DEF];
  longint col_lbl [MAX_SIZE_DEF];
  longint slack   [MAX_SIZE_DEF];
  int     row_mate[MAX_SIZE_DEF];
  int     col_mate[MAX_SIZE_DEF];
  int     slack_row[MAX_SIZE_DEF];
  int     parent  [MAX_SIZE_DEF];
  bit     row_seen[MAX_SIZE_DEF];
  bit     col_seen[MAX_SIZE_DEF];

  int  fail_cnt;
  bit  idle_en;
  bit  long_hold_req;
  int  send_gap;
  int  recv_gap;
  int  hold_left;

  function automatic int unsigned eff_size();
    if (size_reg == 0) return 1;
    if (size_reg > MAX_SIZE_DEF) return MAX_SIZE_DEF;
    return size_reg;
  endfunction

  function automatic longint cost_at(int n, int r, int c);
    return longint'(cost_mem[r*n + c]);
  endfunction

  // Hungarian method, tree rooted at the first unmatched row; an early return
  // leaves the remaining columns unmatched.
  function automatic void solve_assignment(int n);
    int     i, j, root, steps, y, x, z, nxt, hops, matched;
    bit     done, found;
    longint m, alpha, v;
    for (i = 0; i < n; i++) begin
      row_mate[i] = NO_IDX;
      col_mate[i] = NO_IDX;
    end
    for (i = 0; i < n; i++) begin
      m = cost_at(n, i, 0);
      for (j = 1; j < n; j++) if (cost_at(n, i, j) < m) m = cost_at(n, i, j);
      row_lbl[i] = m;
    end
    for (j = 0; j < n; j++) begin
      m = cost_at(n, 0, j) - row_lbl[0];
      for (i = 1; i < n; i++)
        if (cost_at(n, i, j) - row_lbl[i] < m) m = cost_at(n, i, j) - row_lbl[i];
      col_lbl[j] = m;
    end
    matched = 0;
    while (matched < n) begin
      root = NO_IDX;
      done = 0;
      for (i = 0; i < n; i++) begin
        parent[i] = NO_IDX;
        row_seen[i] = 0;
        col_seen[i] = 0;
      end
      for (i = n - 1; i >= 0; i--) if (row_mate[i] == NO_IDX) root = i;
      if (root == NO_IDX) return;
      row_seen[root] = 1;
      for (j = 0; j < n; j++) begin
        slack[j] = cost_at(n, root, j) - row_lbl[root] - col_lbl[j];
        slack_row[j] = root;
      end
      for (steps = 0; steps <= n + 1 && !done; steps++) begin
        y = NO_IDX;
        for (j = 0; j < n; j++) if (slack[j] == 0 && !col_seen[j]) y = j;
        if (y == NO_IDX) begin
          found = 0;
          alpha = 0;
          for (j = 0; j < n; j++)
            if (!col_seen[j] && (!found || slack[j] < alpha)) begin
              alpha = slack[j];
              found = 1;
            end
          if (!found) return;
          for (i = 0; i < n; i++) begin
            if (row_seen[i]) row_lbl[i] += alpha;
            if (col_seen[i]) col_lbl[i] -= alpha;
          end
          for (j = 0; j < n; j++)
            if (!col_seen[j]) begin
              slack[j] -= alpha;
              if (slack[j] == 0) y = j;
            end
          if (y == NO_IDX) return;
        end
        if (col_mate[y] == NO_IDX) begin
          // augment along the alternating path back to the root
          hops = 0;
          parent[y] = slack_row[y];
          while (y != NO_IDX && hops <= n) begin
            x = parent[y];
            if (x < 0 || x >= n) return;
            col_mate[y] = x;
            nxt = row_mate[x];
            row_mate[x] = y;
            y = nxt;
            hops++;
          end
          matched++;
          done = 1;
        end else begin
          z = col_mate[y];
          parent[y] = slack_row[y];
          row_seen[z] = 1;
          col_seen[y] = 1;
          for (j = 0; j < n; j++) begin
            v = cost_at(n, z, j) - row_lbl[z] - col_lbl[j];
            if (slack[j] > v) begin
              slack[j] = v;
              slack_row[j] = z;
            end
          end
        end
      end
      if (!done) return;
    end
  endfunction

  // Load one accepted cost; on the last entry solve and queue n matches
  function automatic void absorb_cost(logic [COST_BITS_DEF-1:0] c, logic is_last);
    int unsigned n;
    match_txn_t  mt;
    n = eff_size();
    if (load_cnt < n*n) begin
      cost_mem[load_cnt] = c;
      load_cnt++;
    end
    if (is_last) begin
      solve_assignment(int'(n));
      load_cnt = 0;
      for (int k = 0; k < int'(n); k++) begin
        mt.column_index = k[IDX_OUT_W-1:0];
        mt.assigned_row = (col_mate[k] >= 0) ? col_mate[k][IDX_OUT_W-1:0] : '0;
        mt.last_result  = (k == int'(n) - 1);
        match_queue.push_back(mt);
      end
    end
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Drive every input to a known value from time zero
  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.cost = '0;
    in_ch.last_entry = 1'b0;
    out_ch.ready = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Cost driver: predict on acceptance, then offer the next queued transaction
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_gap <= 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) absorb_cost(in_ch.cost, in_ch.last_entry);
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_ch.valid <= 1'b0;
      end else if (cost_queue.size() > 0) begin
        in_ch.valid <= 1'b1;
        in_ch.cost <= cost_queue[0].cost;
        in_ch.last_entry <= cost_queue[0].last_entry;
        void'(cost_queue.pop_front());
        if (idle_en && $urandom_range(0, 9) == 0) send_gap <= $urandom_range(1, 19);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stall bursts, plus one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      recv_gap <= 0;
      hold_left <= 0;
    end else if (long_hold_req && hold_left == 0) begin
      hold_left <= LONG_HOLD_CYCLES;
      long_hold_req <= 1'b0;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= (hold_left == 1);
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      out_ch.ready <= (recv_gap == 1);
    end else if (idle_en && $urandom_range(0, 9) == 0) begin
      recv_gap <= $urandom_range(1, 19);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Result monitor: compare against the oldest predicted match
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (match_queue.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10)
          $display("unexpected match: col %0d row %0d last %0d", out_ch.column_index,
                   out_ch.assigned_row, out_ch.last_result);
      end else begin
        if (out_ch.column_index !== match_queue[0].column_index ||
            out_ch.assigned_row !== match_queue[0].assigned_row ||
            out_ch.last_result  !== match_queue[0].last_result) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("mismatch: exp col %0d row %0d last %0d, got col %0d row %0d last %0d",
                     match_queue[0].column_index, match_queue[0].assigned_row,
                     match_queue[0].last_result, out_ch.column_index,
                     out_ch.assigned_row, out_ch.last_result);
        end
        void'(match_queue.pop_front());
      end
    end
  end

  // Hold until everything queued has gone in and every match has come out
  task automatic drain();
    wait (cost_queue.size() == 0 && !in_ch.valid && match_queue.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_size(int unsigned v);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= v[CFG_W-1:0];
    @(posedge clk);
    size_reg = v;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic push_cost(int unsigned c, bit is_last);
    cost_txn_t t;
    t.cost = c[COST_BITS_DEF-1:0];
    t.last_entry = is_last;
    cost_queue.push_back(t);
  endtask

  // Queue one n-by-n matrix; style picks tie-heavy, full-range or masked costs
  task automatic push_matrix(int n, int style, int extra);
    int unsigned c, mask;
    mask = $urandom_range(0, 2**COST_BITS_DEF - 1);
    for (int k = 0; k < n*n + extra; k++) begin
      case (style)
        0:       c = $urandom_range(0, 3);
        1:       c = $urandom_range(0, 2**COST_BITS_DEF - 1);
        default: c = $urandom_range(0, 2**COST_BITS_DEF - 1) & mask;
      endcase
      push_cost(c, k == n*n + extra - 1);
    end
  endtask

  int sent;
  int n_pick;

  initial begin
    fail_cnt = 0;
    load_cnt = 0;
    size_reg = 1;
    idle_en = 1'b0;
    long_hold_req = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);

    // Size at its reset value: a single entry of the largest cost
    push_cost(2**COST_BITS_DEF - 1, 1'b1);
    // Anti-diagonal minimum, a tie-heavy random matrix, then an all-zero matrix where ties decide
    write_size(2);
    push_cost(2**COST_BITS_DEF - 1, 0); push_cost(0, 0);
    push_cost(0, 0); push_cost(2**COST_BITS_DEF - 1, 1);
    push_matrix(2, 0, 0);
    for (int k = 0; k < 4; k++) push_cost(0, k == 3);
    // Extra costs past n*n are dropped
    write_size(3);
    push_matrix(3, 1, 3);
    // Oversized register acts as the maximum; shrink mid-load so the load is full
    write_size(127);
    for (int k = 0; k < 5; k++) push_cost($urandom_range(0, 2**COST_BITS_DEF - 1), 0);
    write_size(0);
    push_cost(7, 1);
    write_size(64);
    for (int k = 0; k < 4; k++) push_cost($urandom_range(0, 15), 0);
    write_size(2);
    push_cost(5, 1);

    // Block fills up while the receiver holds off
    write_size(2);
    long_hold_req <= 1'b1;
    for (int k = 0; k < 6; k++) push_matrix(2, k % 3, 0);

    // Random matrices with idling on both sides until over 300 costs are sent, sender pausing at each resize
    idle_en = 1'b1;
    sent = 0;
    while (sent < 380) begin
      if (sent > 300) idle_en = 1'b0;
      case ($urandom_range(0, 9))
        0:       n_pick = 1;
        1, 2:    n_pick = $urandom_range(7, 8);
        default: n_pick = $urandom_range(2, 6);
      endcase
      if (sent == 100) n_pick = 12;
      write_size(n_pick);
      for (int r = 0; r < $urandom_range(1, 3); r++) begin
        push_matrix(n_pick, $urandom_range(0, 2), ($urandom_range(0, 7) == 0) ? 2 : 0);
        sent += n_pick*n_pick;
      end
    end

    drain();
    repeat (100) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("[min_cost_assignment_solver] OK");
    end else begin
      $display("[min_cost_assignment_solver] ERROR");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("[min_cost_assignment_solver] ERROR");
    $finish;
  end

endmodule
